// ===== rtl/core/rgbd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbd_pkg
// Shared types and constants of the RGB frame stream deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package rgbd_pkg;

  // Result field widths
  localparam int unsigned FIELD_W    = 16;
  localparam int unsigned COLOUR_W   = 8;
  localparam int unsigned MAX_DIM_W  = 16;

  // Frame layout
  localparam int unsigned HEADER_BYTES    = 8;
  localparam int unsigned BYTES_PER_PIXEL = 3;

  localparam logic [MAX_DIM_W-1:0] MAX_DIM_RESET = 16'd7680;

  // Input ops
  localparam logic OP_DATA    = 1'b0;
  localparam logic OP_RESTART = 1'b1;

  typedef enum logic [1:0] {
    KIND_FRAME_START = 2'd0,
    KIND_PIXEL       = 2'd1,
    KIND_DIM_ERROR   = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t                kind;
    logic [FIELD_W-1:0]   frame_width;
    logic [FIELD_W-1:0]   frame_height;
    logic [COLOUR_W-1:0]  red;
    logic [COLOUR_W-1:0]  green;
    logic [COLOUR_W-1:0]  blue;
    logic [FIELD_W-1:0]   pixel_x;
    logic [FIELD_W-1:0]   pixel_y;
    logic                 end_of_frame;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/core/rgbd_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbd_parser
// Header/pixel parser state and the per-word result logic.
// ----------------------------------------------------------------------------
`default_nettype none

module rgbd_parser #(
  parameter int unsigned DIM_BITS = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            step,
  input  wire logic                            op,
  input  wire logic [7:0]                      data_byte,
  input  wire logic [rgbd_pkg::MAX_DIM_W-1:0]  max_dimension,
  output logic                                 has_result,
  output rgbd_pkg::result_t                    res
);

  // Stored dimensions never exceed max_dimension, so 16 bits cover them
  localparam int unsigned DW = (DIM_BITS < rgbd_pkg::FIELD_W) ? DIM_BITS
                                                              : rgbd_pkg::FIELD_W;
  localparam logic [32:0] DIM_LIMIT_W = (33'd1 << DIM_BITS) - 33'd1;
  localparam logic [31:0] DIM_LIMIT   = DIM_LIMIT_W[31:0];
  localparam int unsigned HIDX_W = $clog2(rgbd_pkg::HEADER_BYTES);
  localparam logic [HIDX_W-1:0] HIDX_LAST = HIDX_W'(rgbd_pkg::HEADER_BYTES - 1);
  localparam logic [1:0] TRIPLE_LAST = 2'(rgbd_pkg::BYTES_PER_PIXEL - 1);

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_PIXELS = 2'd1,
    PH_HALTED = 2'd2
  } phase_t;

  phase_t             phase, phase_next;
  logic [HIDX_W-1:0]  hdr_idx, hdr_idx_next;
  logic [7:0]         hdr [rgbd_pkg::HEADER_BYTES-1];
  logic [DW-1:0]      cur_width, cur_width_next;
  logic [DW-1:0]      cur_height, cur_height_next;
  logic [DW-1:0]      col_count, col_count_next;
  logic [DW-1:0]      row_count, row_count_next;
  logic [1:0]         triple, triple_next;
  logic [7:0]         held_red, held_red_next;
  logic [7:0]         held_green, held_green_next;

  logic [31:0] hw, hh;
  logic        w_ok, h_ok;
  logic        last_col, last_row, eof;

  // Width is bytes 0..3, height bytes 4..6 plus the incoming byte
  assign hw = {hdr[3], hdr[2], hdr[1], hdr[0]};
  assign hh = {data_byte, hdr[6], hdr[5], hdr[4]};

  assign w_ok = (hw != 32'd0) && (hw <= {16'd0, max_dimension}) && (hw <= DIM_LIMIT);
  assign h_ok = (hh != 32'd0) && (hh <= {16'd0, max_dimension}) && (hh <= DIM_LIMIT);

  assign last_col = ({1'b0, col_count} + 1'b1) >= {1'b0, cur_width};
  assign last_row = ({1'b0, row_count} + 1'b1) >= {1'b0, cur_height};
  assign eof      = last_col && last_row;

  always_comb begin
    phase_next      = phase;
    hdr_idx_next    = hdr_idx;
    cur_width_next  = cur_width;
    cur_height_next = cur_height;
    col_count_next  = col_count;
    row_count_next  = row_count;
    triple_next     = triple;
    held_red_next   = held_red;
    held_green_next = held_green;
    has_result      = 1'b0;
    res             = '0;

    if (op == rgbd_pkg::OP_RESTART) begin
      phase_next      = PH_HEADER;
      hdr_idx_next    = '0;
      cur_width_next  = '0;
      cur_height_next = '0;
      col_count_next  = '0;
      row_count_next  = '0;
      triple_next     = '0;
      held_red_next   = '0;
      held_green_next = '0;
    end else begin
      case (phase)
        PH_HEADER: begin
          hdr_idx_next = hdr_idx + 1'b1;
          if (hdr_idx == HIDX_LAST) begin
            has_result       = 1'b1;
            res.frame_width  = (|hw[31:16]) ? 16'hFFFF : hw[15:0];
            res.frame_height = (|hh[31:16]) ? 16'hFFFF : hh[15:0];
            if (!w_ok || !h_ok) begin
              res.kind   = rgbd_pkg::KIND_DIM_ERROR;
              phase_next = PH_HALTED;
            end else begin
              res.kind        = rgbd_pkg::KIND_FRAME_START;
              cur_width_next  = hw[DW-1:0];
              cur_height_next = hh[DW-1:0];
              col_count_next  = '0;
              row_count_next  = '0;
              triple_next     = '0;
              phase_next      = PH_PIXELS;
            end
          end
        end
        PH_PIXELS: begin
          if (triple == 2'd0) begin
            held_red_next = data_byte;
            triple_next   = 2'd1;
          end else if (triple != TRIPLE_LAST) begin
            held_green_next = data_byte;
            triple_next     = triple + 1'b1;
          end else begin
            has_result       = 1'b1;
            res.kind         = rgbd_pkg::KIND_PIXEL;
            res.frame_width  = rgbd_pkg::FIELD_W'(cur_width);
            res.frame_height = rgbd_pkg::FIELD_W'(cur_height);
            res.red          = held_red;
            res.green        = held_green;
            res.blue         = data_byte;
            res.pixel_x      = rgbd_pkg::FIELD_W'(col_count);
            res.pixel_y      = rgbd_pkg::FIELD_W'(row_count);
            res.end_of_frame = eof;
            triple_next      = '0;
            if (eof) begin
              phase_next     = PH_HEADER;
              hdr_idx_next   = '0;
              col_count_next = '0;
              row_count_next = '0;
            end else if (last_col) begin
              col_count_next = '0;
              row_count_next = row_count + 1'b1;
            end else begin
              col_count_next = col_count + 1'b1;
            end
          end
        end
        default: begin
          // halted (and the unused code): drop data
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_HEADER;
      hdr_idx    <= '0;
      cur_width  <= '0;
      cur_height <= '0;
      col_count  <= '0;
      row_count  <= '0;
      triple     <= '0;
      held_red   <= '0;
      held_green <= '0;
    end else if (step) begin
      phase      <= phase_next;
      hdr_idx    <= hdr_idx_next;
      cur_width  <= cur_width_next;
      cur_height <= cur_height_next;
      col_count  <= col_count_next;
      row_count  <= row_count_next;
      triple     <= triple_next;
      held_red   <= held_red_next;
      held_green <= held_green_next;
    end
  end

  // Header bytes are each written before use, so no reset
  always_ff @(posedge clk) begin
    if (step && (op == rgbd_pkg::OP_DATA) && (phase == PH_HEADER) &&
        (hdr_idx != HIDX_LAST)) begin
      hdr[hdr_idx] <= data_byte;
    end
  end

`ifndef NO_ASSERTIONS
  a_dims_nonzero: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_PIXELS) |-> (cur_width != '0) && (cur_height != '0))
    else $error("pixel phase with a zero dimension");

  a_pos_in_frame: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_PIXELS) |-> (col_count < cur_width) && (row_count < cur_height))
    else $error("pixel position outside frame");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/rgb_frame_stream_deframer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_frame_stream_deframer
// Splits a byte stream into frame-start, pixel and error words.
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+-----------------------------------
//  in       | sink      | in_valid/in_stall  | op, data_byte
//  out      | source    | out_valid/out_stall| kind, frame_width, frame_height,
//           |           |                    | red, green, blue, pixel_x,
//           |           |                    | pixel_y, end_of_frame
//  cfg      | sink      | cfg_valid/cfg_ready| max_dimension
//
//  One input word per cycle while the output does not stall. A word passes
//  the input register, then parser logic into the result register.
//  rst (synchronous) clears the parser, empties both registers and sets
//  max_dimension to 7680.
//  A stalled output holds the result register; the input register still
//  takes one word and, if that word gives no result, keeps flowing.
//  Write max_dimension only while the block holds no word.
//
`default_nettype none

module rgb_frame_stream_deframer #(
  parameter int unsigned DIM_BITS = 16
) (
  input  wire logic                             clk,
  input  wire logic                             rst,

  // input words
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic                             op,
  input  wire logic [7:0]                       data_byte,

  // result words
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic [1:0]                            kind,
  output logic [rgbd_pkg::FIELD_W-1:0]          frame_width,
  output logic [rgbd_pkg::FIELD_W-1:0]          frame_height,
  output logic [rgbd_pkg::COLOUR_W-1:0]         red,
  output logic [rgbd_pkg::COLOUR_W-1:0]         green,
  output logic [rgbd_pkg::COLOUR_W-1:0]         blue,
  output logic [rgbd_pkg::FIELD_W-1:0]          pixel_x,
  output logic [rgbd_pkg::FIELD_W-1:0]          pixel_y,
  output logic                                  end_of_frame,

  // configuration
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [rgbd_pkg::MAX_DIM_W-1:0]   max_dimension
);

  // Input register
  logic        s1_valid;
  logic        s1_op;
  logic [7:0]  s1_byte;

  // Config register
  logic [rgbd_pkg::MAX_DIM_W-1:0] max_dim;

  // Result register
  rgbd_pkg::result_t out_res;

  logic              has_result;
  rgbd_pkg::result_t res;
  logic              advance;
  logic              load;

  // A word leaves the input register unless its result would hit a full,
  // stalled result register.
  assign advance  = s1_valid && (!has_result || !out_valid || !out_stall);
  assign in_stall = s1_valid && !advance;
  assign load     = in_valid && !in_stall;

  // Accept writes only with the input register empty
  assign cfg_ready = !s1_valid;

  rgbd_parser #(
    .DIM_BITS (DIM_BITS)
  ) u_parser (
    .clk           (clk),
    .rst           (rst),
    .step          (advance),
    .op            (s1_op),
    .data_byte     (s1_byte),
    .max_dimension (max_dim),
    .has_result    (has_result),
    .res           (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      max_dim   <= rgbd_pkg::MAX_DIM_RESET;
    end else begin
      if (load) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end

      if (advance && has_result) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end

      if (cfg_valid && cfg_ready) begin
        max_dim <= max_dimension;
      end
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk) begin
    if (load) begin
      s1_op   <= op;
      s1_byte <= data_byte;
    end
    if (advance && has_result) begin
      out_res <= res;
    end
  end

  assign kind         = out_res.kind;
  assign frame_width  = out_res.frame_width;
  assign frame_height = out_res.frame_height;
  assign red          = out_res.red;
  assign green        = out_res.green;
  assign blue         = out_res.blue;
  assign pixel_x      = out_res.pixel_x;
  assign pixel_y      = out_res.pixel_y;
  assign end_of_frame = out_res.end_of_frame;

`ifndef NO_ASSERTIONS
  a_eof_at_corner: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_res.kind == rgbd_pkg::KIND_PIXEL) && out_res.end_of_frame) |->
      ((out_res.pixel_x + 16'd1) == out_res.frame_width) &&
      ((out_res.pixel_y + 16'd1) == out_res.frame_height))
    else $error("end of frame away from the last pixel");

  a_header_word_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_res.kind != rgbd_pkg::KIND_PIXEL)) |->
      (out_res.red == '0) && (out_res.pixel_x == '0) && (out_res.pixel_y == '0) &&
      !out_res.end_of_frame)
    else $error("pixel fields set on a header word");
`endif

endmodule

`default_nettype wire
